[rtl/apl_pkg.sv]
// ----------------------------------------------------------------------------
// apl_pkg
// Constants, breakpoint tables and shared types of the piecewise linear map.
// ----------------------------------------------------------------------------
package apl_pkg;

    localparam int NUM_POINTS  = 10;
    localparam int FRAC_BITS   = 8;
    localparam int TABLE_SLOTS = 16;
    localparam int K_W         = $clog2(TABLE_SLOTS);
    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 12;
    localparam int HALF_W      = 4;
    localparam int DB_W        = 14;

    localparam int VAL_W   = HALF_W + FRAC_BITS - 1;
    localparam int NUM_W   = FRAC_BITS + DB_W + 1;
    localparam int RECIP_S = FRAC_BITS + DB_W;
    localparam int RECIP_W = RECIP_S;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int REM_W   = DB_W + 1;
    localparam int RES_W   = VAL_W + 1;

    localparam logic [OUT_W-1:0] ABOVE_RESET = 12'd1664;
    localparam logic [OUT_W-1:0] OUT_MAX     = '1;

    // slots past the tenth repeat the last point
    localparam int BP_TAB [TABLE_SLOTS] = '{
        -20200, -19451, -18664, -6690, 2350, 9459, 14452, 18465, 18740, 20192,
        20192, 20192, 20192, 20192, 20192, 20192
    };

    // position values in halves
    localparam int HALF_TAB [TABLE_SLOTS] = '{
        0, 1, 2, 4, 6, 8, 10, 12, 13, 13, 13, 13, 13, 13, 13, 13
    };

    // segment widths, entry k spans breakpoint k-1 to k
    localparam int DB_TAB [TABLE_SLOTS] = '{
        0,
        BP_TAB[1] - BP_TAB[0], BP_TAB[2] - BP_TAB[1], BP_TAB[3] - BP_TAB[2],
        BP_TAB[4] - BP_TAB[3], BP_TAB[5] - BP_TAB[4], BP_TAB[6] - BP_TAB[5],
        BP_TAB[7] - BP_TAB[6], BP_TAB[8] - BP_TAB[7], BP_TAB[9] - BP_TAB[8],
        0, 0, 0, 0, 0, 0
    };

    localparam longint ONE_S = longint'(1) << RECIP_S;

    // floor reciprocals of the segment widths, scaled by two to the RECIP_S
    localparam logic [RECIP_W-1:0] RECIP_TAB [TABLE_SLOTS] = '{
        '0,
        RECIP_W'(ONE_S / DB_TAB[1]), RECIP_W'(ONE_S / DB_TAB[2]),
        RECIP_W'(ONE_S / DB_TAB[3]), RECIP_W'(ONE_S / DB_TAB[4]),
        RECIP_W'(ONE_S / DB_TAB[5]), RECIP_W'(ONE_S / DB_TAB[6]),
        RECIP_W'(ONE_S / DB_TAB[7]), RECIP_W'(ONE_S / DB_TAB[8]),
        RECIP_W'(ONE_S / DB_TAB[9]),
        '0, '0, '0, '0, '0, '0
    };

    typedef enum logic [1:0] {
        CLS_BELOW,
        CLS_EQUAL,
        CLS_INTERP,
        CLS_ABOVE
    } apl_cls_t;

    typedef struct packed {
        apl_cls_t       cls;
        logic [K_W-1:0] k;
    } apl_ctl_t;

    typedef struct packed {
        apl_ctl_t         ctl;
        logic [VAL_W-1:0] base;
        logic [Q_W-1:0]   qe;
        logic [REM_W-1:0] rem;
    } apl_ip_t;

    function automatic logic [VAL_W-1:0] val_q(logic [K_W-1:0] k);
        return VAL_W'(HALF_TAB[k]) << (FRAC_BITS - 1);
    endfunction

endpackage

[rtl/apl_seg_find.sv]
// ----------------------------------------------------------------------------
// apl_seg_find
// First stage: compares the sample with every breakpoint and classifies it.
// ----------------------------------------------------------------------------
module apl_seg_find (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [apl_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [apl_pkg::SAMPLE_W-1:0]  out_sample,
    output apl_pkg::apl_ctl_t                    out_ctl
);
    import apl_pkg::*;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    apl_ctl_t                   ctl_reg;
    apl_ctl_t                   ctl_next;
    logic [TABLE_SLOTS-1:0]     le;
    logic [TABLE_SLOTS-1:0]     eq;
    logic [K_W-1:0]             k_sel;
    logic                       found;

    always_comb begin
        found = 1'b0;
        k_sel = '0;
        // downward scan so the lowest breakpoint at or above the sample wins
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            le[i] = (i < NUM_POINTS) && (int'(in_sample) <= BP_TAB[i]);
            eq[i] = (i < NUM_POINTS) && (int'(in_sample) == BP_TAB[i]);
            if (le[i]) begin
                found = 1'b1;
                k_sel = K_W'(i);
            end
        end
        ctl_next.k = k_sel;
        if (!found) begin
            ctl_next.cls = CLS_ABOVE;
        end else if (k_sel == '0) begin
            ctl_next.cls = CLS_BELOW;
        end else if (eq[k_sel]) begin
            ctl_next.cls = CLS_EQUAL;
        end else if (k_sel == K_W'(NUM_POINTS - 1)) begin
            ctl_next.cls = CLS_ABOVE;
        end else begin
            ctl_next.cls = CLS_INTERP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= in_sample;
            ctl_reg    <= ctl_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_ctl    = ctl_reg;

endmodule

[rtl/apl_interp.sv]
// ----------------------------------------------------------------------------
// apl_interp
// Three stages: offset into the segment, reciprocal multiply, remainder.
// ----------------------------------------------------------------------------
module apl_interp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [apl_pkg::SAMPLE_W-1:0]  in_sample,
    input  apl_pkg::apl_ctl_t                    in_ctl,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output apl_pkg::apl_ip_t                     out_ip
);
    import apl_pkg::*;

    // stage 2: offset and scaled numerator
    logic [K_W-1:0]    k_lo;
    logic [DB_W-1:0]   r;
    logic [HALF_W-1:0] hd;
    logic [NUM_W-1:0]  num_next;
    logic [VAL_W-1:0]  base_next;
    logic              v2_reg;
    apl_ctl_t          ctl2_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [VAL_W-1:0]  base2_reg;
    logic              rdy2;

    // stage 3: quotient estimate
    logic [NUM_W+RECIP_W-1:0] prod3;
    logic [Q_W-1:0]           qe_next;
    logic                     v3_reg;
    apl_ctl_t                 ctl3_reg;
    logic [NUM_W-1:0]         num3_reg;
    logic [VAL_W-1:0]         base3_reg;
    logic [Q_W-1:0]           qe3_reg;
    logic                     rdy3;

    // stage 4: remainder for the final correction
    logic [NUM_W-1:0] prod4;
    logic [NUM_W-1:0] rem4;
    apl_ip_t          ip_next;
    logic             v4_reg;
    apl_ip_t          ip4_reg;
    logic             rdy4;

    always_comb begin
        k_lo      = in_ctl.k - K_W'(1);
        r         = DB_W'(int'(in_sample) - BP_TAB[k_lo]);
        hd        = HALF_W'(HALF_TAB[in_ctl.k] - HALF_TAB[k_lo]);
        num_next  = (NUM_W'(r) * NUM_W'(hd)) << (FRAC_BITS - 1);
        base_next = val_q((in_ctl.cls == CLS_EQUAL) ? in_ctl.k : k_lo);
    end

    always_comb begin
        prod3   = (NUM_W+RECIP_W)'(num2_reg) * (NUM_W+RECIP_W)'(RECIP_TAB[ctl2_reg.k]);
        qe_next = Q_W'(prod3 >> RECIP_S);
    end

    always_comb begin
        prod4        = NUM_W'(qe3_reg) * NUM_W'(DB_TAB[ctl3_reg.k]);
        rem4         = num3_reg - prod4;
        ip_next.ctl  = ctl3_reg;
        ip_next.base = base3_reg;
        ip_next.qe   = qe3_reg;
        ip_next.rem  = REM_W'(rem4);
    end

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy2) begin
            ctl2_reg  <= in_ctl;
            num2_reg  <= num_next;
            base2_reg <= base_next;
        end
        if (v2_reg && rdy3) begin
            ctl3_reg  <= ctl2_reg;
            num3_reg  <= num2_reg;
            base3_reg <= base2_reg;
            qe3_reg   <= qe_next;
        end
        if (v3_reg && rdy4) begin
            ip4_reg <= ip_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_ip    = ip4_reg;

endmodule

[rtl/adc_piecewise_linear_map.sv]
// ----------------------------------------------------------------------------
// adc_piecewise_linear_map
// Maps signed converter samples to an unsigned Q4.8 position by table lookup
// and linear interpolation between ten fixed breakpoints.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one request per sample on s_adc_sample.
//   m_valid/m_ready return one result per sample, in order: m_mapped_value
//   and m_out_of_range (set at or below the first breakpoint, and in the
//   last segment short of the last breakpoint or beyond it, where the
//   programmed above-range value is returned).
//   cfg_wr_en with cfg_wr_data writes the above-range value; write it only
//   while no request is in flight. Reset value is 1664 (6.5).
// Timing:
//   the accepting edge loads the breakpoint compare stage, and m_valid rises
//   after the segment offset, reciprocal multiply, remainder, and correction
//   into the output register. One request per cycle is accepted while the
//   receiver takes results.
// Reset and stall:
//   reset empties every stage and restores the above-range value. When
//   m_ready is low the result holds; empty stages keep filling, and s_ready
//   drops only once all five stages hold a request.
// ----------------------------------------------------------------------------
module adc_piecewise_linear_map (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [apl_pkg::SAMPLE_W-1:0]  s_adc_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [apl_pkg::OUT_W-1:0]            m_mapped_value,
    output logic                                 m_out_of_range,
    input  logic                                 cfg_wr_en,
    input  logic [apl_pkg::OUT_W-1:0]            cfg_wr_data
);
    import apl_pkg::*;

    logic                       sf_valid;
    logic                       sf_ready;
    logic signed [SAMPLE_W-1:0] sf_sample;
    apl_ctl_t                   sf_ctl;

    logic                       ip_valid;
    logic                       ip_ready;
    apl_ip_t                    ip;

    logic [OUT_W-1:0] above_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] mapped_reg;
    logic             oor_reg;

    logic [DB_W-1:0]  db;
    logic [Q_W-1:0]   q;
    logic [RES_W-1:0] res;
    logic [RES_W-1:0] base_w;
    logic [OUT_W-1:0] res_sat;
    logic [OUT_W-1:0] base_sat;
    logic [OUT_W-1:0] mapped_next;
    logic             oor_next;

    apl_seg_find u_seg_find (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_adc_sample),
        .out_valid  (sf_valid),
        .out_ready  (sf_ready),
        .out_sample (sf_sample),
        .out_ctl    (sf_ctl)
    );

    apl_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sf_valid),
        .in_ready  (sf_ready),
        .in_sample (sf_sample),
        .in_ctl    (sf_ctl),
        .out_valid (ip_valid),
        .out_ready (ip_ready),
        .out_ip    (ip)
    );

    always_comb begin
        db     = DB_W'(DB_TAB[ip.ctl.k]);
        // estimate is at most one below the true quotient
        q      = ip.qe + Q_W'(ip.rem >= REM_W'(db));
        res    = RES_W'(ip.base) + RES_W'(q);
        base_w = RES_W'(ip.base);
        res_sat  = (32'(res) > 32'(OUT_MAX)) ? OUT_MAX : OUT_W'(res);
        base_sat = (32'(base_w) > 32'(OUT_MAX)) ? OUT_MAX : OUT_W'(base_w);
        mapped_next = '0;
        oor_next    = 1'b1;
        unique case (ip.ctl.cls)
            CLS_BELOW: begin
                mapped_next = '0;
                oor_next    = 1'b1;
            end
            CLS_EQUAL: begin
                mapped_next = base_sat;
                oor_next    = 1'b0;
            end
            CLS_INTERP: begin
                mapped_next = res_sat;
                oor_next    = 1'b0;
            end
            CLS_ABOVE: begin
                mapped_next = above_reg;
                oor_next    = 1'b1;
            end
            default: begin
                mapped_next = above_reg;
                oor_next    = 1'b1;
            end
        endcase
    end

    assign ip_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            above_reg   <= ABOVE_RESET;
        end else begin
            if (ip_ready) begin
                m_valid_reg <= ip_valid;
            end
            if (cfg_wr_en) begin
                above_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ip_valid && ip_ready) begin
            mapped_reg <= mapped_next;
            oor_reg    <= oor_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mapped_value = mapped_reg;
    assign m_out_of_range = oor_reg;

    // a ready receiver lets every stage advance, so the input is never held
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // reciprocal estimate must leave a remainder below twice the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ip_valid && ip.ctl.cls == CLS_INTERP) |->
            ((REM_W+1)'(ip.rem) < ((REM_W+1)'(db) << 1)))
        else $error("quotient estimate off by more than one");

    // an exact hit on the first breakpoint is classed as below range
    a_equal_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (ip_valid && ip.ctl.cls == CLS_EQUAL) |-> (ip.ctl.k != '0))
        else $error("breakpoint hit classed on first point");

endmodule
